// File: hdl/ipv4_fragment_header_generator_core_defines.svh
// Assertion macros shared by the fragment header generator RTL.
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_CORE_DEFINES_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define FHG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FHG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FHG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FHG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/ipv4fhg_pkg.sv
package ipv4fhg_pkg;

  localparam int unsigned BASE_HEADER_BYTES = 20;
  localparam logic [13:0] MTU_RESET = 14'd1500;
  localparam logic [13:0] MIN_CHUNK = 14'd1216;
  localparam logic [15:0] FLAG_MF   = 16'h2000;
  localparam logic [15:0] FLAG_DF   = 16'h4000;
  localparam logic [3:0]  IP_VERSION = 4'h4;
  localparam logic [3:0]  BASE_IHL  = 4'd5;
  localparam logic [15:0] CSUM_ALL_ONES = 16'hffff;

  // Control of the shared ones-complement accumulator.
  typedef struct packed {
    logic load;
    logic add;
  } csum_ctrl_t;

endpackage

// File: hdl/ipv4_fragment_header_generator_core.sv
// Sequence: the packet word is taken in idle, then six setup adds and a save, then
//   four adds, a fold and an emit per fragment for N fragments (N up to 54)
//   through one shared 16-bit ones-complement accumulator; the emit holds while
//   the result side stalls. No new packet word is taken until the last
//   fragment's word is taken.
// Reset: rst_n is synchronous, active low; clears the sequencer, drops out_valid
//   and sets the MTU register to 1500.
`include "ipv4_fragment_header_generator_core_defines.svh"

module ipv4_fragment_header_generator_core
  import ipv4fhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_mtu,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [7:0]  in_time_to_live,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_type_of_service,
  input  logic [15:0] in_ident,
  input  logic [15:0] in_flags_word,
  input  logic [3:0]  in_options_words,
  input  logic [15:0] in_options_sum,
  input  logic [15:0] in_payload_len,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_payload_start,
  output logic [15:0] out_fragment_len,
  output logic [15:0] out_total_len,
  output logic [3:0]  out_header_words,
  output logic [15:0] out_flags_offset_word,
  output logic [15:0] out_header_checksum,
  output logic        out_options_present,
  output logic        out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a packet word
    ST_SETUP,  // sum the words shared by every fragment
    ST_BASE,   // save that partial sum
    ST_FRAG,   // add the per-fragment words
    ST_FIN,    // fold into the checksum, load the result word
    ST_EMIT    // hold the result word until taken
  } state_t;

  state_t      state_r;
  logic [2:0]  step_r;
  logic [13:0] mtu_r;

  // Captured packet word.
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [7:0]  ttl_r;
  logic [7:0]  proto_r;
  logic [7:0]  tos_r;
  logic [15:0] id_r;
  logic [15:0] flags_r;
  logic [3:0]  ow_r;
  logic [15:0] osum_r;
  logic [15:0] plen_r;

  // Fragment walk.
  logic [13:0] chunk_r;
  logic [15:0] ofs_r;
  logic [15:0] left_r;
  logic        first_r;
  logic [15:0] base_r;

  // Result word registers.
  logic        out_valid_r;
  logic [15:0] out_start_r;
  logic [15:0] out_flen_r;
  logic [15:0] out_tlen_r;
  logic [3:0]  out_ihl_r;
  logic [15:0] out_fl_r;
  logic [15:0] out_ck_r;
  logic        out_opts_r;
  logic        out_last_r;

  logic        in_accept;
  logic        out_accept;

  // Chunk size from the MTU and the option length of the incoming packet.
  logic [14:0] room;
  logic        room_neg;
  logic [13:0] room_al;
  logic [13:0] chunk_c;

  assign room     = {1'b0, mtu_r} - 15'(BASE_HEADER_BYTES) - {9'd0, in_options_words, 2'b00};
  assign room_neg = room[14];
  assign room_al  = {room[13:3], 3'b000};
  assign chunk_c  = (room_neg || (room_al < MIN_CHUNK)) ? MIN_CHUNK : room_al;

  // Per-fragment header fields, all combinational from the packet and walk registers.
  logic        has_opts;
  logic        pass_c;
  logic        is_last;
  logic        with_opts;
  logic [3:0]  ihl_c;
  logic [5:0]  obytes_c;
  logic [15:0] flen_c;
  logic [15:0] tlen_c;
  logic [15:0] fl_raw;
  logic [15:0] fl_c;
  logic [15:0] ck_inv;
  logic [15:0] ck_c;

  assign has_opts  = (ow_r != 4'd0);
  assign pass_c    = flags_r[13] || (plen_r == 16'd0) || (plen_r <= {2'b00, chunk_r});
  assign is_last   = pass_c || (left_r <= {2'b00, chunk_r});
  // Non-passthrough: only the first fragment carries options, never the last.
  assign with_opts = has_opts && (pass_c || (first_r && !is_last));
  assign ihl_c     = with_opts ? (BASE_IHL + ow_r) : BASE_IHL;
  assign obytes_c  = with_opts ? {ow_r, 2'b00} : 6'd0;
  assign flen_c    = is_last ? left_r : {2'b00, chunk_r};
  assign tlen_c    = 16'(BASE_HEADER_BYTES) + {10'd0, obytes_c} + flen_c;

  always_comb begin
    if (pass_c) begin
      fl_raw = flags_r;
    end else if (is_last) begin
      fl_raw = {3'b000, ofs_r[15:3]};
    end else begin
      fl_raw = FLAG_MF | {3'b000, ofs_r[15:3]};
    end
  end

  // An all-zero flags word goes out as DF.
  assign fl_c = (fl_raw == 16'd0) ? FLAG_DF : fl_raw;

  // Shared accumulator.
  csum_ctrl_t  csum_ctrl;
  logic [15:0] csum_init;
  logic [15:0] csum_word;
  logic [15:0] csum_sum;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  always_comb begin
    csum_ctrl.load = in_accept || (out_accept && !out_last_r);
    csum_ctrl.add  = (state_r == ST_SETUP) || (state_r == ST_FRAG);
    csum_init      = (state_r == ST_IDLE) ? 16'd0 : base_r;
  end

  always_comb begin
    csum_word = 16'd0;
    if (state_r == ST_SETUP) begin
      unique case (step_r)
        3'd0:    csum_word = src_r[31:16];
        3'd1:    csum_word = src_r[15:0];
        3'd2:    csum_word = dst_r[31:16];
        3'd3:    csum_word = dst_r[15:0];
        3'd4:    csum_word = id_r;
        3'd5:    csum_word = {ttl_r, proto_r};
        default: csum_word = 16'd0;
      endcase
    end else if (state_r == ST_FRAG) begin
      unique case (step_r)
        3'd0:    csum_word = {IP_VERSION, ihl_c, tos_r};
        3'd1:    csum_word = tlen_c;
        3'd2:    csum_word = fl_c;
        3'd3:    csum_word = with_opts ? osum_r : 16'd0;
        default: csum_word = 16'd0;
      endcase
    end
  end

  ipv4fhg_csum_unit u_csum (
    .clk  (clk),
    .ctrl (csum_ctrl),
    .init (csum_init),
    .word (csum_word),
    .sum  (csum_sum)
  );

  // A zero checksum goes out as all ones.
  assign ck_inv = ~csum_sum;
  assign ck_c   = (ck_inv == 16'd0) ? CSUM_ALL_ONES : ck_inv;

  // Sequencer: state, step count, walk registers and result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      mtu_r       <= MTU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mtu_r <= cfg_mtu;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            src_r   <= in_src_addr;
            dst_r   <= in_dst_addr;
            ttl_r   <= in_time_to_live;
            proto_r <= in_protocol;
            tos_r   <= in_type_of_service;
            id_r    <= in_ident;
            flags_r <= in_flags_word;
            ow_r    <= in_options_words;
            osum_r  <= in_options_sum;
            plen_r  <= in_payload_len;
            chunk_r <= chunk_c;
            ofs_r   <= 16'd0;
            left_r  <= in_payload_len;
            first_r <= 1'b1;
            step_r  <= 3'd0;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          // Advance through the six shared words.
          if (step_r == 3'd5) begin
            step_r  <= 3'd0;
            state_r <= ST_BASE;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_BASE: begin
          base_r  <= csum_sum;
          step_r  <= 3'd0;
          state_r <= ST_FRAG;
        end
        ST_FRAG: begin
          if (step_r == 3'd3) begin
            step_r  <= 3'd0;
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_FIN: begin
          out_start_r <= ofs_r;
          out_flen_r  <= flen_c;
          out_tlen_r  <= tlen_c;
          out_ihl_r   <= ihl_c;
          out_fl_r    <= fl_c;
          out_ck_r    <= ck_c;
          out_opts_r  <= with_opts;
          out_last_r  <= is_last;
          out_valid_r <= 1'b1;
          state_r     <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold the word until taken, then step to the next fragment.
          if (out_accept) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              ofs_r   <= ofs_r + {2'b00, chunk_r};
              left_r  <= left_r - {2'b00, chunk_r};
              first_r <= 1'b0;
              step_r  <= 3'd0;
              state_r <= ST_FRAG;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);

  assign out_valid             = out_valid_r;
  assign out_payload_start     = out_start_r;
  assign out_fragment_len      = out_flen_r;
  assign out_total_len         = out_tlen_r;
  assign out_header_words      = out_ihl_r;
  assign out_flags_offset_word = out_fl_r;
  assign out_header_checksum   = out_ck_r;
  assign out_options_present   = out_opts_r;
  assign out_last              = out_last_r;

  `FHG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall && !out_valid, "block not busy after packet word taken")
  `FHG_ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_accept && out_last, !in_stall, "block not idle after last word")
  `FHG_ASSERT_IMPL(a_opts_at_start, clk, rst_n, out_valid && out_options_present, out_payload_start == 16'd0, "options on a fragment past offset zero")
  `FHG_ASSERT_IMPL(a_mf_on_middle, clk, rst_n, out_valid && !out_last, out_flags_offset_word[13] && (out_fragment_len[2:0] == 3'd0), "non-final fragment lacks MF or 8-byte alignment")
  `FHG_ASSERT_IMPL(a_nonzero_ck, clk, rst_n, out_valid, out_header_checksum != 16'd0, "zero checksum emitted")

endmodule

// File: hdl/ipv4fhg_csum_unit.sv
module ipv4fhg_csum_unit
  import ipv4fhg_pkg::*;
(
  input  logic        clk,
  input  csum_ctrl_t  ctrl,
  input  logic [15:0] init,
  input  logic [15:0] word,
  output logic [15:0] sum
);

  logic [15:0] acc_r;
  logic [15:0] acc_nxt;
  logic [16:0] raw;

  // One 16-bit word per cycle while add is set and load is not, with end-around carry.
  assign raw = {1'b0, acc_r} + {1'b0, word};

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load) begin
      acc_nxt = init;
    end else if (ctrl.add) begin
      acc_nxt = raw[15:0] + {15'd0, raw[16]};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign sum = acc_r;

endmodule
